// ----- rtl/assert_macros.svh -----
// Assertion helpers for the RTL file that carries checks (inverse_normal_cdf.sv).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: implication failed");
`define ASSERT_NEVER(name, clk, rst, cond) \
   name: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("%m: forbidden condition seen");
`else
`define ASSERT_IMPLIES(name, clk, rst, ante, cons)
`define ASSERT_NEVER(name, clk, rst, cond)
`endif
`endif

// ----- rtl/inc_pkg.sv -----
`timescale 1ns / 1ps
package inc_pkg;

   localparam int M_W         = 31;
   localparam int FRAC_W      = 30;
   localparam int LOG_STEPS   = 30;
   localparam int Y_W         = 37;
   localparam int V_W         = 64;
   localparam int T_W         = V_W / 2;
   localparam int SQ_REM_W    = T_W + 2;
   localparam int SQRT_STEPS  = V_W / 2;
   localparam int POLY_STAGES = 4;
   localparam int NUM_W       = 33;
   localparam int DEN_W       = 35;
   localparam int RAT_W       = 33;
   localparam int DIV_STEPS   = RAT_W;
   localparam int QUANT_W     = 24;

   localparam logic [30:0] K2LN2   = 31'd1488522236;
   localparam logic [31:0] C0_Q28  = 32'd675253953;
   localparam logic [31:0] C1_Q28  = 32'd215514211;
   localparam logic [31:0] C2_Q28  = 32'd2772401;
   localparam logic [31:0] D0_Q28  = 32'd384611100;
   localparam logic [31:0] D1_Q28  = 32'd50806510;
   localparam logic [31:0] D2_Q28  = 32'd351114;
   localparam logic [31:0] ONE_Q28 = 32'd268435456;

   typedef struct packed {
      logic valid;
      logic neg;
      logic invalid;
   } inc_side_type;

   function automatic logic [35:0] mul_q28(input logic [31:0] a, input logic [31:0] b);
      logic [63:0] p;
      p = a * b;
      return p[63:28];
   endfunction

endpackage

// ----- rtl/inc_log_cell.sv -----
`timescale 1ns / 1ps
module inc_log_cell (
   input  logic                        clock,
   input  logic [inc_pkg::M_W-1:0]     m_prev,
   input  logic [inc_pkg::FRAC_W-1:0]  frac_prev,
   output logic [inc_pkg::M_W-1:0]     m_next,
   output logic [inc_pkg::FRAC_W-1:0]  frac_next
);
   import inc_pkg::*;

   logic [2*M_W-1:0]  sq;
   logic [M_W:0]      sq_hi;
   logic [M_W-1:0]    m_in, m_ff;
   logic [FRAC_W-1:0] frac_in, frac_ff;

   always_comb begin
      sq    = m_prev * m_prev;
      sq_hi = sq[2*M_W-1:FRAC_W];
      if (sq_hi[M_W]) begin
         m_in    = sq_hi[M_W:1];
         frac_in = {frac_prev[FRAC_W-2:0], 1'b1};
      end else begin
         m_in    = sq_hi[M_W-1:0];
         frac_in = {frac_prev[FRAC_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      m_ff    <= m_in;
      frac_ff <= frac_in;
   end

   assign m_next    = m_ff;
   assign frac_next = frac_ff;
endmodule

// ----- rtl/inc_sqrt_cell.sv -----
`timescale 1ns / 1ps
module inc_sqrt_cell (
   input  logic                          clock,
   input  logic [inc_pkg::SQ_REM_W-1:0]  rem_prev,
   input  logic [inc_pkg::T_W-1:0]       root_prev,
   input  logic [inc_pkg::V_W-1:0]       v_prev,
   output logic [inc_pkg::SQ_REM_W-1:0]  rem_next,
   output logic [inc_pkg::T_W-1:0]       root_next,
   output logic [inc_pkg::V_W-1:0]       v_next
);
   import inc_pkg::*;

   logic [SQ_REM_W+1:0] rem_sh, trial;
   logic [SQ_REM_W-1:0] rem_in, rem_ff;
   logic [T_W-1:0]      root_in, root_ff;
   logic [V_W-1:0]      v_ff;

   always_comb begin
      rem_sh = {rem_prev, v_prev[V_W-1:V_W-2]};
      trial  = {2'b00, root_prev, 2'b01};
      if (rem_sh >= trial) begin
         rem_in  = SQ_REM_W'(rem_sh - trial);
         root_in = {root_prev[T_W-2:0], 1'b1};
      end else begin
         rem_in  = rem_sh[SQ_REM_W-1:0];
         root_in = {root_prev[T_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      root_ff <= root_in;
      v_ff    <= {v_prev[V_W-3:0], 2'b00};
   end

   assign rem_next  = rem_ff;
   assign root_next = root_ff;
   assign v_next    = v_ff;
endmodule

// ----- rtl/inc_div_cell.sv -----
`timescale 1ns / 1ps
module inc_div_cell (
   input  logic                       clock,
   input  logic [inc_pkg::DEN_W-1:0]  den_prev,
   input  logic [inc_pkg::DEN_W-1:0]  rem_prev,
   input  logic [inc_pkg::RAT_W-1:0]  quo_prev,
   input  logic [inc_pkg::RAT_W-1:0]  bits_prev,
   output logic [inc_pkg::DEN_W-1:0]  den_next,
   output logic [inc_pkg::DEN_W-1:0]  rem_next,
   output logic [inc_pkg::RAT_W-1:0]  quo_next,
   output logic [inc_pkg::RAT_W-1:0]  bits_next
);
   import inc_pkg::*;

   logic [DEN_W:0]   rem_sh;
   logic [DEN_W-1:0] rem_in, rem_ff, den_ff;
   logic [RAT_W-1:0] quo_in, quo_ff, bits_ff;

   always_comb begin
      rem_sh = {rem_prev, bits_prev[RAT_W-1]};
      if (rem_sh >= {1'b0, den_prev}) begin
         rem_in = DEN_W'(rem_sh - {1'b0, den_prev});
         quo_in = {quo_prev[RAT_W-2:0], 1'b1};
      end else begin
         rem_in = rem_sh[DEN_W-1:0];
         quo_in = {quo_prev[RAT_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      den_ff  <= den_prev;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      bits_ff <= {bits_prev[RAT_W-2:0], 1'b0};
   end

   assign den_next  = den_ff;
   assign rem_next  = rem_ff;
   assign quo_next  = quo_ff;
   assign bits_next = bits_ff;
endmodule

// ----- rtl/inc_poly.sv -----
`timescale 1ns / 1ps
module inc_poly (
   input  logic                       clock,
   input  logic [inc_pkg::T_W-1:0]    t_in,
   output logic [inc_pkg::NUM_W-1:0]  num_out,
   output logic [inc_pkg::DEN_W-1:0]  den_out
);
   import inc_pkg::*;

   logic [T_W-1:0]   t1_ff, t2_ff;
   logic [31:0]      a2_ff, d2_ff, n1_ff, e1_ff;
   logic [NUM_W-1:0] num3_ff, num4_ff;
   logic [DEN_W-1:0] e2_ff, den4_ff;
   logic [35:0]      a2_in, d2_in, n1_in, e1_in, e2_in;

   always_comb begin
      a2_in = mul_q28(C2_Q28, t_in);
      d2_in = mul_q28(D2_Q28, t_in);
      n1_in = mul_q28(C1_Q28 + a2_ff, t1_ff);
      e1_in = mul_q28(D1_Q28 + d2_ff, t1_ff);
      e2_in = mul_q28(D0_Q28 + e1_ff, t2_ff);
   end

   always_ff @(posedge clock) begin
      t1_ff   <= t_in;
      a2_ff   <= a2_in[31:0];
      d2_ff   <= d2_in[31:0];
      t2_ff   <= t1_ff;
      n1_ff   <= n1_in[31:0];
      e1_ff   <= e1_in[31:0];
      num3_ff <= NUM_W'(C0_Q28) + NUM_W'(n1_ff);
      e2_ff   <= e2_in[DEN_W-1:0];
      num4_ff <= num3_ff;
      den4_ff <= DEN_W'(ONE_Q28) + e2_ff;
   end

   assign num_out = num4_ff;
   assign den_out = den4_ff;
endmodule

// ----- rtl/inverse_normal_cdf.sv -----
// A result strobe follows its accepted transaction through the registered stages in order:
// input and normalization, 30 log squaring cells, the logarithm stages, 32 square root cells,
// 4 polynomial stages, 33 divider cells, rounding and output. One transaction can be accepted
// in every cycle in which busy is low, so throughput is one per cycle.
// Reset is synchronous and active high, clears all in-flight transactions and holds busy
// high for the cycle after it; the receiver cannot stall, so busy is otherwise low.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module inverse_normal_cdf #(
   parameter int INPUT_BITS       = 32,
   parameter int OUTPUT_FRAC_BITS = 20
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [INPUT_BITS-1:0]               req_prob_fraction,
   output logic                                busy,
   output logic                                rsp_valid,
   output logic signed [inc_pkg::QUANT_W-1:0]  rsp_quantile,
   output logic                                rsp_invalid
);
   import inc_pkg::*;

   localparam int LZ_W     = $clog2(INPUT_BITS + 1);
   localparam int LINT_W   = $clog2(INPUT_BITS + 2);
   localparam int LN_ST    = LOG_STEPS + 2;
   localparam int Y_ST     = LN_ST + 1;
   localparam int SQRT_END = Y_ST + SQRT_STEPS;
   localparam int POLY_END = SQRT_END + POLY_STAGES;
   localparam int DIV_END  = POLY_END + DIV_STEPS;
   localparam int R_ST     = DIV_END + 1;
   localparam int SIDE_N   = R_ST + 1;
   localparam int LATENCY  = R_ST + 2;
   localparam int TD       = POLY_STAGES + DIV_STEPS;
   localparam int DIVD_W   = NUM_W + 28;
   localparam int R_W      = RAT_W + 2;
   localparam int ABS_W    = RAT_W + 1;
   localparam int MAG_W    = 40;
   localparam int RND_SH   = (OUTPUT_FRAC_BITS < 28) ? 28 - OUTPUT_FRAC_BITS : 0;
   localparam int LSH      = (OUTPUT_FRAC_BITS > 28) ? OUTPUT_FRAC_BITS - 28 : 0;
   localparam logic [MAG_W-1:0] RND_ADD = (MAG_W'(1) << RND_SH) >> 1;
   localparam logic [MAG_W-1:0] MAG_LIM = MAG_W'(1) << (QUANT_W - 1);
   localparam logic [MAG_W-1:0] MAG_MAX = MAG_LIM - MAG_W'(1);

   logic                  accept;
   logic                  busy_ff;
   inc_side_type          side_in;
   inc_side_type          side_ff [0:SIDE_N-1];
   logic [INPUT_BITS-1:0] q_in, q_ff;

   logic [LZ_W-1:0]             lz;
   logic [INPUT_BITS-1:0]       norm;
   logic [INPUT_BITS+M_W-1:0]   ext;
   logic [M_W-1:0]              m_ff;
   logic [LZ_W-1:0]             lz_ff [0:LOG_STEPS];

   logic [M_W-1:0]    m_w    [0:LOG_STEPS];
   logic [FRAC_W-1:0] frac_w [0:LOG_STEPS];

   logic [LINT_W-1:0]   lint;
   logic [FRAC_W-1:0]   lfr;
   logic [LINT_W+30:0]  pint;
   logic [FRAC_W+30:0]  pfr;
   logic [Y_W-1:0]      pint_ff, y_ff;
   logic [30:0]         pfr_ff;

   logic [SQ_REM_W-1:0] srem_w [0:SQRT_STEPS];
   logic [T_W-1:0]      root_w [0:SQRT_STEPS];
   logic [V_W-1:0]      v_w    [0:SQRT_STEPS];

   logic [NUM_W-1:0]    num_w;
   logic [DEN_W-1:0]    den_p;
   logic [DIVD_W-1:0]   divd;
   logic [DEN_W-1:0]    den_w  [0:DIV_STEPS];
   logic [DEN_W-1:0]    drem_w [0:DIV_STEPS];
   logic [RAT_W-1:0]    quo_w  [0:DIV_STEPS];
   logic [RAT_W-1:0]    bits_w [0:DIV_STEPS];
   logic [T_W-1:0]      t_dly_ff [0:TD-1];

   logic signed [R_W-1:0] r;
   logic [ABS_W-1:0]      abs_in, abs_ff;
   logic                  flip_ff;
   logic [MAG_W-1:0]      mag;
   logic [QUANT_W-1:0]    quant_in, quant_ff;
   logic                  rsp_valid_ff, rsp_invalid_ff;

   assign accept = start && !busy_ff;
   assign busy   = busy_ff;

   always_comb begin
      side_in.valid   = accept;
      side_in.neg     = !req_prob_fraction[INPUT_BITS-1];
      side_in.invalid = (req_prob_fraction == '0);
      q_in = side_in.neg ? req_prob_fraction : (~req_prob_fraction + INPUT_BITS'(1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
         for (int k = 0; k < SIDE_N; k++) begin
            side_ff[k] <= '0;
         end
      end else begin
         busy_ff    <= 1'b0;
         side_ff[0] <= side_in;
         for (int k = 1; k < SIDE_N; k++) begin
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
   end

   always_comb begin
      lz = LZ_W'(INPUT_BITS);
      for (int i = 0; i < INPUT_BITS; i++) begin
         if (q_ff[i]) begin
            lz = LZ_W'(INPUT_BITS - 1 - i);
         end
      end
      norm = q_ff << lz;
      ext  = {norm, M_W'(0)};
   end

   always_ff @(posedge clock) begin
      m_ff     <= ext[INPUT_BITS+M_W-1 -: M_W];
      lz_ff[0] <= lz;
      for (int k = 1; k <= LOG_STEPS; k++) begin
         lz_ff[k] <= lz_ff[k-1];
      end
   end

   assign m_w[0]    = m_ff;
   assign frac_w[0] = '0;

   for (genvar j = 0; j < LOG_STEPS; j++) begin : g_log
      inc_log_cell u_cell (
         .clock     (clock),
         .m_prev    (m_w[j]),
         .frac_prev (frac_w[j]),
         .m_next    (m_w[j+1]),
         .frac_next (frac_w[j+1])
      );
   end

   always_comb begin
      if (frac_w[LOG_STEPS] == '0) begin
         lint = LINT_W'(lz_ff[LOG_STEPS]) + LINT_W'(1);
         lfr  = '0;
      end else begin
         lint = LINT_W'(lz_ff[LOG_STEPS]);
         lfr  = ~frac_w[LOG_STEPS] + FRAC_W'(1);
      end
      pint = lint * K2LN2;
      pfr  = lfr * K2LN2;
   end

   always_ff @(posedge clock) begin
      pint_ff <= Y_W'(pint);
      pfr_ff  <= pfr[FRAC_W+30:FRAC_W];
      y_ff    <= pint_ff + Y_W'(pfr_ff);
   end

   assign srem_w[0] = '0;
   assign root_w[0] = '0;
   assign v_w[0]    = V_W'({y_ff, 26'b0});

   for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
      inc_sqrt_cell u_cell (
         .clock     (clock),
         .rem_prev  (srem_w[j]),
         .root_prev (root_w[j]),
         .v_prev    (v_w[j]),
         .rem_next  (srem_w[j+1]),
         .root_next (root_w[j+1]),
         .v_next    (v_w[j+1])
      );
   end

   inc_poly u_poly (
      .clock   (clock),
      .t_in    (root_w[SQRT_STEPS]),
      .num_out (num_w),
      .den_out (den_p)
   );

   always_ff @(posedge clock) begin
      t_dly_ff[0] <= root_w[SQRT_STEPS];
      for (int k = 1; k < TD; k++) begin
         t_dly_ff[k] <= t_dly_ff[k-1];
      end
   end

   assign divd      = {num_w, 28'b0};
   assign den_w[0]  = den_p;
   assign drem_w[0] = DEN_W'(divd[DIVD_W-1:RAT_W]);
   assign quo_w[0]  = '0;
   assign bits_w[0] = divd[RAT_W-1:0];

   for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
      inc_div_cell u_cell (
         .clock     (clock),
         .den_prev  (den_w[j]),
         .rem_prev  (drem_w[j]),
         .quo_prev  (quo_w[j]),
         .bits_prev (bits_w[j]),
         .den_next  (den_w[j+1]),
         .rem_next  (drem_w[j+1]),
         .quo_next  (quo_w[j+1]),
         .bits_next (bits_w[j+1])
      );
   end

   always_comb begin
      r      = $signed(R_W'(t_dly_ff[TD-1])) - $signed(R_W'(quo_w[DIV_STEPS]));
      abs_in = r[R_W-1] ? ABS_W'(-r) : ABS_W'(r);
   end

   always_ff @(posedge clock) begin
      abs_ff  <= abs_in;
      flip_ff <= side_ff[DIV_END].neg ^ r[R_W-1];
   end

   always_comb begin
      mag = ((MAG_W'(abs_ff) + RND_ADD) >> RND_SH) << LSH;
      if (side_ff[R_ST].invalid) begin
         quant_in = '0;
      end else if (flip_ff) begin
         quant_in = (mag >= MAG_LIM) ? MAG_LIM[QUANT_W-1:0] : QUANT_W'(-mag);
      end else begin
         quant_in = (mag > MAG_MAX) ? MAG_MAX[QUANT_W-1:0] : mag[QUANT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= side_ff[R_ST].valid;
      end
      rsp_invalid_ff <= side_ff[R_ST].invalid;
      quant_ff       <= quant_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_invalid  = rsp_invalid_ff;
   assign rsp_quantile = $signed(quant_ff);

   `ASSERT_IMPLIES(a_invalid_zero, clock, reset, rsp_valid && rsp_invalid, rsp_quantile == '0)
   `ASSERT_IMPLIES(a_latency, clock, reset, rsp_valid, $past(start && !busy, LATENCY))
   `ASSERT_NEVER(a_den_low, clock, reset, side_ff[POLY_END].valid && den_p < DEN_W'(ONE_Q28))
endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
module testbench;

   localparam int LATENCY = 105;
   localparam int WATCHDOG_LIMIT = 2000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic [31:0] req_prob_fraction = '0;
   logic busy;
   logic rsp_valid;
   logic signed [inc_pkg::QUANT_W-1:0] rsp_quantile;
   logic rsp_invalid;

   typedef struct {
      logic signed [23:0] quantile;
      logic invalid;
   } quantile_result_type;

   logic [31:0] pending_probs[$];
   int pending_gaps[$];
   bit pending_drain[$];
   quantile_result_type expected_quantiles[$];
   int error_count = 0;
   int idle_cycles = 0;
   int gap_left = 0;
   bit waiting_drain = 0;
   bit stimulus_done = 0;

   inverse_normal_cdf dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .req_prob_fraction(req_prob_fraction),
      .busy(busy),
      .rsp_valid(rsp_valid),
      .rsp_quantile(rsp_quantile),
      .rsp_invalid(rsp_invalid)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic logic [63:0] root64(input logic [63:0] v);
      logic [63:0] res;
      logic [63:0] bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v = v - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   function automatic logic [63:0] fix_mul(input logic [63:0] a, input logic [63:0] b);
      logic [63:0] p;
      p = a * b;
      return p >> 28;
   endfunction

   function automatic logic [63:0] minus_two_ln(input logic [63:0] q);
      int e;
      logic [63:0] m;
      logic [63:0] frac;
      logic [63:0] l2;
      e = 63;
      frac = 0;
      while (e > 0 && q[e] == 1'b0) e--;
      if (e >= 30) m = q >> (e - 30);
      else m = q << (30 - e);
      for (int i = 0; i < 30; i++) begin
         m = (m * m) >> 30;
         frac = frac << 1;
         if (m >= (64'd2 << 30)) begin
            m = m >> 1;
            frac = frac | 64'd1;
         end
      end
      l2 = (64'(32 - e) << 30) - frac;
      return (l2 >> 30) * 64'd1488522236
         + (((l2 & ((64'd1 << 30) - 1)) * 64'd1488522236) >> 30);
   endfunction

   function automatic quantile_result_type predict_quantile(input logic [31:0] x);
      quantile_result_type res;
      bit neg;
      bit rneg;
      logic [63:0] q, y, t, num, den, ratio, mag;
      longint r, val;
      if (x == 0) begin
         res.quantile = 0;
         res.invalid = 1'b1;
         return res;
      end
      neg = x < 32'h8000_0000;
      q = neg ? 64'(x) : (64'h1_0000_0000 - 64'(x));
      y = minus_two_ln(q);
      t = root64(y << 26);
      num = 64'd675253953 + fix_mul(t, 64'd215514211 + fix_mul(64'd2772401, t));
      den = (64'd1 << 28) + fix_mul(t, 64'd384611100
         + fix_mul(t, 64'd50806510 + fix_mul(64'd351114, t)));
      ratio = (num << 28) / den;
      r = longint'(t) - longint'(ratio);
      rneg = r < 0;
      mag = rneg ? 64'(-r) : 64'(r);
      mag = (mag + (64'd1 << 7)) >> 8;
      if (mag > (64'd1 << 40)) mag = 64'd1 << 40;
      val = longint'(mag);
      if (neg != rneg) val = -val;
      if (val > 8388607) val = 8388607;
      if (val < -8388608) val = -8388608;
      res.quantile = val[23:0];
      res.invalid = 1'b0;
      return res;
   endfunction

   function automatic int random_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 40);
   endfunction

   task automatic add_item(input logic [31:0] p, input int gap, input bit drain);
      pending_probs.push_back(p);
      pending_gaps.push_back(gap);
      pending_drain.push_back(drain);
   endtask

   initial begin
      logic [31:0] p;
      int kind;
      add_item(32'h0000_0000, 0, 0);
      add_item(32'h0000_0001, 0, 0);
      add_item(32'h0000_0002, 0, 0);
      add_item(32'hFFFF_FFFF, 0, 0);
      add_item(32'hFFFF_FFFE, 0, 0);
      add_item(32'h8000_0000, 0, 0);
      add_item(32'h7FFF_FFFF, 0, 0);
      add_item(32'h8000_0001, 0, 0);
      add_item(32'h4000_0000, 0, 0);
      add_item(32'hC000_0000, 0, 0);
      add_item(32'h5555_5555, 0, 0);
      add_item(32'hAAAA_AAAA, 0, 0);
      add_item(32'h0001_0000, 0, 0);
      add_item(32'hFFFF_0000, 0, 0);
      for (int i = 0; i < 1000; i++) begin
         kind = $urandom_range(0, 9);
         case (kind)
            0: p = $urandom_range(0, 1023);
            1: p = 32'hFFFF_FFFF - $urandom_range(0, 1023);
            2: p = 32'h8000_0000 + $urandom_range(0, 64) - 32;
            3: p = $urandom >> $urandom_range(0, 31);
            default: p = $urandom;
         endcase
         add_item(p, random_gap(), i == 500 || i == 800);
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            expected_quantiles.push_back(predict_quantile(req_prob_fraction));
         end
         if (start && busy) begin
            start <= 1'b1;
         end else if (gap_left > 0) begin
            start <= 1'b0;
            gap_left <= gap_left - 1;
         end else if (waiting_drain) begin
            start <= 1'b0;
            if (expected_quantiles.size() == 0) waiting_drain <= 0;
         end else if (pending_probs.size() > 0) begin
            start <= 1'b1;
            req_prob_fraction <= pending_probs.pop_front();
            gap_left <= pending_gaps.pop_front();
            waiting_drain <= pending_drain.pop_front();
         end else begin
            start <= 1'b0;
            req_prob_fraction <= $urandom;
            if (!stimulus_done && !start) stimulus_done <= 1;
         end
      end
   end

   always @(posedge clock) begin
      quantile_result_type exp_res;
      if (!reset && rsp_valid) begin
         if (expected_quantiles.size() == 0) begin
            $display("%0t: unexpected transaction, actual quantile %0d invalid %0b",
               $time, rsp_quantile, rsp_invalid);
            error_count++;
         end else begin
            exp_res = expected_quantiles.pop_front();
            if (rsp_quantile !== exp_res.quantile) begin
               $display("%0t: quantile mismatch, expected %0d actual %0d",
                  $time, exp_res.quantile, rsp_quantile);
               error_count++;
            end
            if (rsp_invalid !== exp_res.invalid) begin
               $display("%0t: invalid mismatch, expected %0b actual %0b",
                  $time, exp_res.invalid, rsp_invalid);
               error_count++;
            end
         end
      end
      if (reset || rsp_valid || (start && !busy)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      while (!(stimulus_done && expected_quantiles.size() == 0)
            && idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("testbench: done, errors");
         $finish;
      end else begin
         repeat (LATENCY + 10) @(posedge clock);
         if (error_count == 0) begin
            $display("testbench: done, clean");
         end else begin
            $display("testbench: done, errors");
         end
         $finish;
      end
   end

endmodule

// ----- inverse_normal_cdf.f -----
+incdir+rtl
rtl/inc_pkg.sv
rtl/inc_log_cell.sv
rtl/inc_sqrt_cell.sv
rtl/inc_div_cell.sv
rtl/inc_poly.sv
rtl/inverse_normal_cdf.sv
bench/testbench.sv
